// File: rtl/core/ggc_pkg.sv
// Package for the greedy graph colorer: sizes, command and status codes.
// Depends on nothing; used by greedy_graph_colorer.
package ggc_pkg;
    localparam int MaxVertices = 64;
    localparam int KeyBits     = 64;
    localparam int IdBits      = $clog2(MaxVertices);
    localparam int CountBits   = $clog2(MaxVertices + 1);

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_COLOR = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2
    } t_status;

    localparam logic signed [6:0] NoColor = -7'sd1;
endpackage

// File: rtl/core/greedy_graph_colorer.sv
// Greedy graph colorer: one command a beat, its answer a beat on o_done.
// Uses ggc_pkg. Keys, adjacency rows and colours live in synchronous memories.
//
// A command is taken when start is high and busy low. Exactly one result beat
// follows, marked by o_done, and the receiver cannot hold it off. The key search
// reads the key memory one entry at a time, alternating S_SRCH and S_SRCH_W. A
// query then reads the colour in S_QRY and S_QRY_W, or answers from S_QRY for an
// unknown key. An add writes new keys in S_ADD_A and S_ADD_B, then sets both row
// bits through S_ROW_RD and S_ROW_WR, or answers ST_FULL when the table is full.
// Colouring first resets every colour in a pass over all 64 entries. It then
// reads each vertex's row and the colour of each lower vertex, or goes straight
// to its answer on an empty graph. Clear walks all 64 entries, one row and one
// colour entry a cycle. A clearing pass over all entries runs after reset with busy high.
module greedy_graph_colorer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_command,
    input  logic [ggc_pkg::KeyBits-1:0]   i_key_first,
    input  logic [ggc_pkg::KeyBits-1:0]   i_key_second,
    output logic                          o_done,
    output logic signed [6:0]             o_color,
    output logic [1:0]                    o_status,
    output logic [6:0]                    o_vertex_count
);
    import ggc_pkg::*;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_SRCH, S_SRCH_W, S_ADD_A, S_ADD_B, S_ROW_RD, S_ROW_WR,
        S_COL_ROW, S_COL_SCAN, S_COL_CHK, S_COL_PICK, S_QRY, S_QRY_W
    } t_state;

    logic [KeyBits-1:0]     r_keys [MaxVertices];
    logic [MaxVertices-1:0] r_rows [MaxVertices];
    logic [6:0]             r_cols [MaxVertices];

    t_state                 r_state;
    logic [CountBits-1:0]   r_total;
    logic [CountBits-1:0]   r_idx;
    logic [1:0]             r_cmd;
    logic [KeyBits-1:0]     r_k1, r_k2;
    logic                   r_fa, r_fb;
    logic [IdBits-1:0]      r_ia, r_ib;
    logic [KeyBits-1:0]     r_key_q;
    logic [MaxVertices-1:0] r_row_q, r_row;
    logic [6:0]             r_col_q;
    logic [MaxVertices-1:0] r_used;
    logic                   r_pass;
    logic [IdBits-1:0]      r_vi, r_vj;
    logic                   r_done;
    logic signed [6:0]      r_color;
    logic [1:0]             r_status;

    logic [IdBits-1:0]      w_pick;
    logic                   w_lhit_a, w_lhit_b;
    logic [CountBits-1:0]   w_need;

    always_comb begin
        w_pick = '0;
        for (int c = MaxVertices - 1; c >= 0; c--) begin
            if (!r_used[c]) begin
                w_pick = IdBits'(c);
            end
        end
    end

    assign w_lhit_a = (r_key_q == r_k1);
    assign w_lhit_b = (r_key_q == r_k2);
    assign w_need = CountBits'(!r_fa) + CountBits'(!r_fb && !(!r_fa && r_k1 == r_k2));

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_idx   <= '0;
            r_total <= '0;
            r_pass  <= 1'b0;
            r_cmd   <= CMD_ADD;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    if (!(r_pass && r_cmd == CMD_COLOR)) begin
                        r_rows[r_idx[IdBits-1:0]] <= '0;
                    end
                    r_cols[r_idx[IdBits-1:0]] <= NoColor;
                    if (r_idx == CountBits'(MaxVertices - 1)) begin
                        r_pass <= 1'b0;
                        if (r_cmd == CMD_COLOR && r_pass) begin
                            r_state <= S_COL_ROW;
                        end else begin
                            r_state <= S_IDLE;
                        end
                        if (r_cmd == CMD_CLEAR && r_pass) begin
                            r_done   <= 1'b1;
                            r_color  <= NoColor;
                            r_status <= ST_OK;
                        end
                    end
                    r_idx <= r_idx + 1'b1;
                end
                S_IDLE: begin
                    if (start) begin
                        r_cmd <= i_command;
                        r_k1  <= i_key_first;
                        r_k2  <= i_key_second;
                        r_fa  <= 1'b0;
                        r_fb  <= 1'b0;
                        r_idx <= '0;
                        unique case (t_cmd'(i_command))
                            CMD_ADD, CMD_QUERY: r_state <= S_SRCH;
                            CMD_COLOR: begin
                                r_vi <= '0;
                                r_state <= (r_total == '0) ? S_COL_PICK : S_CLR;
                                r_pass <= 1'b1;
                            end
                            CMD_CLEAR: begin
                                r_total <= '0;
                                r_pass  <= 1'b1;
                                r_state <= S_CLR;
                            end
                        endcase
                    end
                end
                S_SRCH: begin
                    if (r_idx == r_total) begin
                        if (r_cmd == CMD_QUERY) begin
                            r_state <= S_QRY;
                        end else if (r_total + w_need > CountBits'(MaxVertices)) begin
                            r_done   <= 1'b1;
                            r_color  <= NoColor;
                            r_status <= ST_FULL;
                            r_state  <= S_IDLE;
                        end else begin
                            r_state <= S_ADD_A;
                        end
                    end else begin
                        r_key_q <= r_keys[r_idx[IdBits-1:0]];
                        r_state <= S_SRCH_W;
                    end
                end
                S_SRCH_W: begin
                    if (w_lhit_a && !r_fa) begin
                        r_fa <= 1'b1;
                        r_ia <= r_idx[IdBits-1:0];
                    end
                    if (w_lhit_b && !r_fb) begin
                        r_fb <= 1'b1;
                        r_ib <= r_idx[IdBits-1:0];
                    end
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_SRCH;
                end
                S_ADD_A: begin
                    if (!r_fa) begin
                        r_keys[r_total[IdBits-1:0]] <= r_k1;
                        r_cols[r_total[IdBits-1:0]] <= NoColor;
                        r_rows[r_total[IdBits-1:0]] <= '0;
                        r_ia    <= r_total[IdBits-1:0];
                        r_fa    <= 1'b1;
                        r_total <= r_total + 1'b1;
                        if (r_k1 == r_k2) begin
                            r_fb <= 1'b1;
                            r_ib <= r_total[IdBits-1:0];
                        end
                    end
                    r_state <= S_ADD_B;
                end
                S_ADD_B: begin
                    if (!r_fb) begin
                        r_keys[r_total[IdBits-1:0]] <= r_k2;
                        r_cols[r_total[IdBits-1:0]] <= NoColor;
                        r_rows[r_total[IdBits-1:0]] <= '0;
                        r_ib    <= r_total[IdBits-1:0];
                        r_fb    <= 1'b1;
                        r_total <= r_total + 1'b1;
                    end
                    r_idx   <= '0;
                    r_state <= S_ROW_RD;
                end
                S_ROW_RD: begin
                    r_row_q <= r_rows[r_idx[0] ? r_ib : r_ia];
                    r_state <= S_ROW_WR;
                end
                S_ROW_WR: begin
                    r_rows[r_idx[0] ? r_ib : r_ia] <=
                        r_row_q | (MaxVertices'(1) << (r_idx[0] ? r_ia : r_ib));
                    if (r_idx[0]) begin
                        r_done   <= 1'b1;
                        r_color  <= NoColor;
                        r_status <= ST_OK;
                        r_state  <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_ROW_RD;
                    end
                end
                S_COL_ROW: begin
                    r_row   <= r_rows[r_vi];
                    r_used  <= '0;
                    r_vj    <= '0;
                    r_state <= (r_vi == '0) ? S_COL_PICK : S_COL_SCAN;
                end
                S_COL_SCAN: begin
                    r_col_q <= r_cols[r_vj];
                    r_state <= S_COL_CHK;
                end
                S_COL_CHK: begin
                    if (r_row[r_vj] && !r_col_q[6]) begin
                        r_used[r_col_q[IdBits-1:0]] <= 1'b1;
                    end
                    r_state <= (r_vj + 1'b1 == r_vi) ? S_COL_PICK : S_COL_SCAN;
                    r_vj    <= r_vj + 1'b1;
                end
                S_COL_PICK: begin
                    if (r_total != '0) begin
                        r_cols[r_vi] <= 7'(w_pick);
                    end
                    if (r_total == '0 || CountBits'(r_vi) + 1'b1 == r_total) begin
                        r_done   <= 1'b1;
                        r_color  <= NoColor;
                        r_status <= ST_OK;
                        r_state  <= S_IDLE;
                    end else begin
                        r_vi    <= r_vi + 1'b1;
                        r_state <= S_COL_ROW;
                    end
                end
                S_QRY: begin
                    if (!r_fa) begin
                        r_done   <= 1'b1;
                        r_color  <= NoColor;
                        r_status <= ST_NOTFOUND;
                        r_state  <= S_IDLE;
                    end else begin
                        r_col_q <= r_cols[r_ia];
                        r_state <= S_QRY_W;
                    end
                end
                S_QRY_W: begin
                    r_done   <= 1'b1;
                    r_color  <= r_col_q;
                    r_status <= ST_OK;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_color        = r_color;
    assign o_status       = r_status;
    assign o_vertex_count = 7'(r_total);

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CountBits'(MaxVertices))
        else $error("vertex count above table size");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == S_IDLE)
        else $error("result beat while still working");
    a_full_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_status == ST_FULL) |-> $stable(r_total))
        else $error("rejected add changed the table");
`endif
endmodule

// File: tb/greedy_graph_colorer_test.sv
// Self-checking testbench for greedy_graph_colorer: directed and random command beats.
// Depends on ggc_pkg and greedy_graph_colorer; a scoreboard class predicts each answer.
// The predictor keeps its own key table, adjacency matrix and colour array.

class colour_scoreboard;
    logic [63:0]        keys[64];
    logic [63:0]        rows[64];
    logic signed [6:0]  colours[64];
    int                 total;
    logic signed [6:0]  want_colour[$];
    logic [1:0]         want_status[$];
    logic [6:0]         want_count[$];
    int                 errors;

    function new();
        errors = 0;
        wipe();
    endfunction

    function void wipe();
        total = 0;
        for (int i = 0; i < 64; i++) begin
            rows[i] = '0;
            colours[i] = ggc_pkg::NoColor;
        end
    endfunction

    function int find(logic [63:0] key);
        for (int i = 0; i < total; i++)
            if (keys[i] == key) return i;
        return -1;
    endfunction

    function void recolour();
        logic [63:0] taken;
        if (total == 0) return;
        for (int i = 0; i < 64; i++) colours[i] = ggc_pkg::NoColor;
        colours[0] = '0;
        for (int i = 1; i < total; i++) begin
            taken = '0;
            for (int j = 0; j < total; j++)
                if (rows[i][j] && colours[j] >= 0) taken[colours[j]] = 1'b1;
            for (int c = 0; c < total; c++)
                if (!taken[c]) begin
                    colours[i] = 7'(c);
                    break;
                end
        end
    endfunction

    function void note_command(ggc_pkg::t_cmd cmd, logic [63:0] k1, logic [63:0] k2);
        logic signed [6:0] col;
        ggc_pkg::t_status st;
        int a, b, need;
        col = ggc_pkg::NoColor;
        st = ggc_pkg::ST_OK;
        case (cmd)
            ggc_pkg::CMD_ADD: begin
                a = find(k1);
                b = find(k2);
                need = (a < 0) + ((b < 0) && !((a < 0) && k1 == k2));
                if (total + need > 64) begin
                    st = ggc_pkg::ST_FULL;
                end else begin
                    if (a < 0) begin
                        a = total;
                        keys[a] = k1;
                        rows[a] = '0;
                        colours[a] = ggc_pkg::NoColor;
                        total++;
                    end
                    if (b < 0) begin
                        if (k1 == k2) begin
                            b = a;
                        end else begin
                            b = total;
                            keys[b] = k2;
                            rows[b] = '0;
                            colours[b] = ggc_pkg::NoColor;
                            total++;
                        end
                    end
                    rows[a][b] = 1'b1;
                    rows[b][a] = 1'b1;
                end
            end
            ggc_pkg::CMD_COLOR: recolour();
            ggc_pkg::CMD_QUERY: begin
                a = find(k1);
                if (a < 0) st = ggc_pkg::ST_NOTFOUND;
                else col = colours[a];
            end
            default: wipe();
        endcase
        want_colour.push_back(col);
        want_status.push_back(st);
        want_count.push_back(7'(total));
    endfunction

    function void check_answer(logic signed [6:0] col, logic [1:0] st, logic [6:0] cnt);
        if (want_colour.size() == 0) begin
            $error("answer beat with nothing outstanding");
            errors++;
            return;
        end
        if (col !== want_colour[0]) begin
            $error("color: expected %0d, got %0d", want_colour[0], col);
            errors++;
        end
        if (st !== want_status[0]) begin
            $error("status: expected %0d, got %0d", want_status[0], st);
            errors++;
        end
        if (cnt !== want_count[0]) begin
            $error("vertex_count: expected %0d, got %0d", want_count[0], cnt);
            errors++;
        end
        void'(want_colour.pop_front());
        void'(want_status.pop_front());
        void'(want_count.pop_front());
    endfunction

    function int outstanding();
        return want_colour.size();
    endfunction
endclass

module greedy_graph_colorer_test;
    import ggc_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_command;
    logic [63:0]       i_key_first;
    logic [63:0]       i_key_second;
    logic              o_done;
    logic signed [6:0] o_color;
    logic [1:0]        o_status;
    logic [6:0]        o_vertex_count;

    colour_scoreboard board;
    logic [63:0]      key_pool[16];
    bit               steady;
    int               idle_cycles;

    greedy_graph_colorer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_command(i_command), .i_key_first(i_key_first), .i_key_second(i_key_second),
        .o_done(o_done), .o_color(o_color), .o_status(o_status),
        .o_vertex_count(o_vertex_count)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    initial begin
        board = new();
        i_rst_n = 1'b0;
        start = 1'b0;
        i_command = CMD_ADD;
        i_key_first = '0;
        i_key_second = '0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) board.check_answer(o_color, o_status, o_vertex_count);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send(t_cmd cmd, logic [63:0] k1, logic [63:0] k2);
        while (!steady && $urandom_range(99) < 30) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_command <= cmd;
        i_key_first <= k1;
        i_key_second <= k2;
        do @(posedge i_clk); while (busy);
        board.note_command(cmd, k1, k2);
    endtask

    function automatic logic [63:0] pick_key();
        if ($urandom_range(9) < 8) return key_pool[$urandom_range(15)];
        return {$urandom, $urandom};
    endfunction

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_cmd cmd;
        int   roll;
        steady = 1'b0;
        for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send(CMD_QUERY, '0, '0);
        send(CMD_COLOR, '0, '0);
        send(CMD_ADD, '0, '1);
        send(CMD_ADD, '1, '1);
        send(CMD_ADD, 64'h5, 64'h5);
        send(CMD_ADD, '0, '1);
        send(CMD_ADD, 64'h5, '0);
        send(CMD_QUERY, '1, '0);
        send(CMD_COLOR, '0, '0);
        send(CMD_QUERY, '0, '0);
        send(CMD_QUERY, '1, '0);
        send(CMD_QUERY, 64'h5, '0);
        send(CMD_QUERY, 64'h1234, '0);
        send(CMD_CLEAR, '0, '0);
        send(CMD_QUERY, '0, '0);
        for (int i = 0; i < 63; i++) send(CMD_ADD, 64'(i), 64'(i + 1));
        send(CMD_ADD, 64'h100, 64'h101);
        send(CMD_ADD, 64'd3, 64'h100);
        send(CMD_ADD, 64'd3, 64'd40);
        send(CMD_COLOR, '0, '0);
        send(CMD_QUERY, 64'd63, '0);
        drain();
        send(CMD_CLEAR, '0, '0);

        for (int n = 0; n < 680; n++) begin
            steady = (n >= 300 && n < 400);
            if (n == 200) drain();
            roll = $urandom_range(99);
            if (roll < 55) cmd = CMD_ADD;
            else if (roll < 63) cmd = CMD_COLOR;
            else if (roll < 97) cmd = CMD_QUERY;
            else cmd = CMD_CLEAR;
            if (cmd == CMD_ADD && $urandom_range(3) == 0)
                send(cmd, {$urandom, $urandom}, {$urandom, $urandom});
            else
                send(cmd, pick_key(), pick_key());
        end
        send(CMD_COLOR, '0, '0);
        for (int i = 0; i < 16; i++) send(CMD_QUERY, key_pool[i], '0);

        drain();
        repeat (200) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
